FILE: rtl/blt_pkg.sv
`default_nettype none

package blt_pkg;

  // fixed-point format and store size
  localparam int FRAC_BITS = 8;
  localparam int MAX_BEATS = 32;
  localparam int ADDR_W    = $clog2(MAX_BEATS);
  localparam int CNT_W     = $clog2(MAX_BEATS + 1);

  // field widths
  localparam int POS_W   = 14;
  localparam int NOTE_W  = 7;
  localparam int CHAN_W  = 4;
  localparam int VOL_W   = 7;
  localparam int BEAT_W  = 26;
  localparam int MB_W    = 6;
  localparam int DUR_W   = 31;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 26;

  // span holds a position difference or measure_beats << FRAC_BITS, sized for (measure_beats + 1) << FRAC_BITS
  localparam int LIM_W  = MB_W + 1 + FRAC_BITS;
  localparam int PROD_W = LIM_W + BEAT_W;

  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  // register reset values
  localparam logic [BEAT_W-1:0] BEAT_TIME_RST    = BEAT_W'(500000);
  localparam logic [MB_W-1:0]   MEASURE_BEATS_RST = MB_W'(4);
  localparam logic [CHAN_W-1:0] REST_CHANNEL_RST  = CHAN_W'(9);

  typedef enum logic [CIDX_W-1:0] {
    REG_BEAT_TIME     = 2'd0,
    REG_MEASURE_BEATS = 2'd1,
    REG_REST_CHANNEL  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              entry_present;
    logic [POS_W-1:0]  beat_position;
    logic [NOTE_W-1:0] note_number;
    logic [CHAN_W-1:0] note_channel;
    logic [VOL_W-1:0]  note_volume;
    logic              end_of_pattern;
  } in_word_t;

  typedef struct packed {
    logic [NOTE_W-1:0] event_note;
    logic [VOL_W-1:0]  event_volume;
    logic [CHAN_W-1:0] event_channel;
    logic [DUR_W-1:0]  event_duration_us;
    logic              last_event;
  } out_word_t;

  // one stored beat entry
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [NOTE_W-1:0] note;
    logic [CHAN_W-1:0] chan;
    logic [VOL_W-1:0]  vol;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request to the duration unit
  typedef struct packed {
    logic             en;
    logic [LIM_W-1:0] span;
  } dur_req_t;

endpackage

`default_nettype wire

FILE: rtl/blt_ram.sv
`default_nettype none

module blt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/blt_dur.sv
`default_nettype none

module blt_dur
  import blt_pkg::*;
(
  input  wire logic              clk,
  input  wire dur_req_t          req,
  input  wire logic [BEAT_W-1:0] beat_time_us,
  output logic      [DUR_W-1:0]  dur_us
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] shifted;

  // span * beat time, registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.span) * PROD_W'(beat_time_us);
    end
  end

  // drop fraction bits, saturate
  assign shifted = prod_r >> FRAC_BITS;
  assign dur_us  = (shifted > PROD_W'(DUR_MAX)) ? DUR_MAX : shifted[DUR_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/beat_list_to_timed_events.sv
`default_nettype none

// Beat list to timed events. Input words load one measure's beat entries
// (position in beats with 8 fraction bits, note, channel, volume) into a
// 32-entry store, one word per cycle. An entry whose position is below
// beat 1 or at or past measure_beats+1 is stored as invalid: it takes a
// place but gives no event. Entries past the 32nd are dropped. The word
// with end_of_pattern set (entry or bare marker) starts emission, and the
// input stays not ready until a closing scan pass finds nothing left to
// emit (for an empty pattern, until the rest is in the output register).
// Emission works group by group, a group being all valid entries
// at the lowest position not yet emitted: one scan pass over the store finds
// the group position, its member count and the next position (capped at the
// end of the measure), then a second pass walks the store in arrival order
// and emits each member. A rest (note 0, volume 0, rest_channel) leads when
// the first group is not on beat 1. Only the last member of a group carries
// a duration; the shared duration unit multiplies the span by beat_time_us
// into a register, drops the fraction bits and saturates to 31 bits. An
// empty pattern gives one full-measure rest; a pattern of only invalid
// entries gives nothing. Per pattern, counted from the end word, each
// group takes a scan pass over the stored entries and a walk of the store
// to its last member, a leading rest adds a step and a closing scan pass
// ends the pattern; a word that the output holds untaken stalls the work.
// The single-ported store read, one entry a cycle while the output does
// not stall, sets the pace. Configuration writes are taken at any time
// but should be made only while idle.

module beat_list_to_timed_events
  import blt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // entry words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_word_t           in_data,
  // event words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_word_t               out_data,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY_OUT,
    S_SCAN_START,
    S_SCAN,
    S_POST,
    S_REST_OUT,
    S_EM_CHK
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers: always ready.
  // ---------------------------------------------------------------------
  logic [BEAT_W-1:0] beat_time_r;
  logic [MB_W-1:0]   measure_beats_r;
  logic [CHAN_W-1:0] rest_channel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_time_r     <= BEAT_TIME_RST;
      measure_beats_r <= MEASURE_BEATS_RST;
      rest_channel_r  <= REST_CHANNEL_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BEAT_TIME:     beat_time_r     <= cfg_data[BEAT_W-1:0];
        REG_MEASURE_BEATS: measure_beats_r <= cfg_data[MB_W-1:0];
        REG_REST_CHANNEL:  rest_channel_r  <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // end of measure: (measure_beats + 1) << FRAC_BITS
  logic [LIM_W-1:0] limit;
  assign limit = (LIM_W'(measure_beats_r) + LIM_W'(1)) << FRAC_BITS;

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  state_t            state_r,     state_nxt;
  logic [CNT_W-1:0]  count_r,     count_nxt;     // entries stored
  logic [ADDR_W-1:0] idx_r,       idx_nxt;       // store index of data now read
  logic              first_r,     first_nxt;     // no group emitted yet
  logic              found_r,     found_nxt;     // scan found a group
  logic              out_valid_r, out_valid_nxt;

  // scan results and payload, no reset needed
  logic [POS_W-1:0]  prev_low_r,  prev_low_nxt;  // position of last group
  logic [POS_W-1:0]  min1_r,      min1_nxt;      // group position
  logic [LIM_W-1:0]  min2_r,      min2_nxt;      // next position, capped
  logic [CNT_W-1:0]  tot_r,       tot_nxt;       // entries above prev_low
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;       // entries at min1
  logic [CNT_W-1:0]  members_r,   members_nxt;   // members left to emit
  out_word_t         out_data_r,  out_data_nxt;

  // store and duration unit
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_word;
  entry_t            rd_entry;
  dur_req_t          dur_req;
  logic [DUR_W-1:0]  dur_us;

  blt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BEATS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  blt_dur u_dur (
    .clk          (clk),
    .req          (dur_req),
    .beat_time_us (beat_time_r),
    .dur_us       (dur_us)
  );

  // spans fed to the duration unit
  logic [LIM_W-1:0] rest_span;
  logic [LIM_W-1:0] group_span;
  logic [LIM_W-1:0] empty_span;

  assign rest_span  = LIM_W'(min1_r) - LIM_W'(ONE_POS);
  assign group_span = (min2_r > LIM_W'(min1_r)) ? (min2_r - LIM_W'(min1_r)) : '0;
  assign empty_span = LIM_W'(measure_beats_r) << FRAC_BITS;

  logic slot_free;
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------
  logic             pos_bad;
  logic [CNT_W-1:0] count_after;
  logic             scan_last;
  logic [POS_W-1:0] p;
  logic [LIM_W-1:0] min_keep;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    prev_low_nxt  = prev_low_r;
    min1_nxt      = min1_r;
    min2_nxt      = min2_r;
    tot_nxt       = tot_r;
    cnt_nxt       = cnt_r;
    members_nxt   = members_r;
    out_data_nxt  = out_data_r;

    wr_en        = 1'b0;
    wr_addr      = count_r[ADDR_W-1:0];
    rd_en        = 1'b0;
    rd_addr      = idx_r + ADDR_W'(1);
    dur_req.en   = 1'b0;
    dur_req.span = group_span;

    // positions outside [1, measure_beats+1) are stored as 0
    pos_bad = (in_data.beat_position < ONE_POS) ||
              (LIM_W'(in_data.beat_position) >= limit);
    wr_entry.pos  = pos_bad ? '0 : in_data.beat_position;
    wr_entry.note = in_data.note_number;
    wr_entry.chan = in_data.note_channel;
    wr_entry.vol  = in_data.note_volume;
    count_after   = count_r;

    p         = rd_entry.pos;
    scan_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
    min_keep  = (LIM_W'(min1_r) < min2_r) ? LIM_W'(min1_r) : min2_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.entry_present && (count_r < CNT_W'(MAX_BEATS))) begin
            wr_en       = 1'b1;
            count_after = count_r + CNT_W'(1);
          end
          count_nxt = count_after;
          if (in_data.end_of_pattern) begin
            prev_low_nxt = '0;
            first_nxt    = 1'b1;
            if (count_after == '0) begin
              dur_req.en   = 1'b1;
              dur_req.span = empty_span;
              state_nxt    = S_EMPTY_OUT;
            end else begin
              state_nxt = S_SCAN_START;
            end
          end
        end
      end

      S_EMPTY_OUT: begin
        if (slot_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.event_note        = '0;
          out_data_nxt.event_volume      = '0;
          out_data_nxt.event_channel     = rest_channel_r;
          out_data_nxt.event_duration_us = dur_us;
          out_data_nxt.last_event        = 1'b1;
          state_nxt                      = S_IDLE;
        end
      end

      S_SCAN_START: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        min2_nxt  = limit;
        tot_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        // lowest, count at lowest, second lowest above the last group
        if (p > prev_low_r) begin
          tot_nxt = tot_r + CNT_W'(1);
          if (!found_r || (p < min1_r)) begin
            if (found_r) begin
              min2_nxt = min_keep;
            end
            min1_nxt  = p;
            cnt_nxt   = CNT_W'(1);
            found_nxt = 1'b1;
          end else if (p == min1_r) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (LIM_W'(p) < min2_r) begin
            min2_nxt = LIM_W'(p);
          end
        end
        if (scan_last) begin
          state_nxt = S_POST;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
          rd_en   = 1'b1;
        end
      end

      S_POST: begin
        if (!found_r) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (first_r && (min1_r != ONE_POS)) begin
          dur_req.en   = 1'b1;
          dur_req.span = rest_span;
          state_nxt    = S_REST_OUT;
        end else begin
          dur_req.en  = 1'b1;
          rd_en       = 1'b1;
          rd_addr     = '0;
          idx_nxt     = '0;
          members_nxt = cnt_r;
          state_nxt   = S_EM_CHK;
        end
      end

      S_REST_OUT: begin
        if (slot_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.event_note        = '0;
          out_data_nxt.event_volume      = '0;
          out_data_nxt.event_channel     = rest_channel_r;
          out_data_nxt.event_duration_us = dur_us;
          out_data_nxt.last_event        = 1'b0;
          dur_req.en                     = 1'b1;
          rd_en                          = 1'b1;
          rd_addr                        = '0;
          idx_nxt                        = '0;
          members_nxt                    = cnt_r;
          state_nxt                      = S_EM_CHK;
        end
      end

      S_EM_CHK: begin
        if (p == min1_r) begin
          if (slot_free) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.event_note    = rd_entry.note;
            out_data_nxt.event_volume  = rd_entry.vol;
            out_data_nxt.event_channel = rd_entry.chan;
            if (members_r == CNT_W'(1)) begin
              // last member: carries the span, last word if nothing above
              out_data_nxt.event_duration_us = dur_us;
              out_data_nxt.last_event        = (tot_r == cnt_r);
              first_nxt                      = 1'b0;
              prev_low_nxt                   = min1_r;
              state_nxt                      = S_SCAN_START;
            end else begin
              out_data_nxt.event_duration_us = '0;
              out_data_nxt.last_event        = 1'b0;
              members_nxt                    = members_r - CNT_W'(1);
              idx_nxt                        = idx_r + ADDR_W'(1);
              rd_en                          = 1'b1;
            end
          end
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
          rd_en   = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // State and registered outputs
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      first_r     <= 1'b1;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      first_r     <= first_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_low_r <= prev_low_nxt;
    min1_r     <= min1_nxt;
    min2_r     <= min2_nxt;
    tot_r      <= tot_nxt;
    cnt_r      <= cnt_nxt;
    members_r  <= members_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
